>>> rtl/ips_pkg.sv
`default_nettype none

package ips_pkg;

  // Field widths of the item formats
  localparam int SAMPLE_W    = 12;
  localparam int PED_W       = 12;
  localparam int CORR_W      = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Configuration register widths
  localparam int THR_W      = 8;
  localparam int PASS_W     = 2;
  localparam int MINC_W     = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PASSES    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = CFG_IDX_W'(3);

  localparam logic              RST_ENABLE    = 1'b1;
  localparam logic [PASS_W-1:0] RST_PASSES    = PASS_W'(3);
  localparam logic [THR_W-1:0]  RST_THRESHOLD = THR_W'(10);
  localparam logic [MINC_W-1:0] RST_MIN_COUNT = MINC_W'(100);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_LAST,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_LIM,
    ST_SCAN,
    ST_PASS_END,
    ST_DIV,
    ST_REPORT
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic              enable;
    logic [PASS_W-1:0] passes;
    logic [THR_W-1:0]  threshold;
    logic [MINC_W-1:0] min_count;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [PED_W-1:0]         pedestal;
    logic signed [CORR_W-1:0] corrected;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/ips_front.sv
`default_nettype none

module ips_front #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                            s_valid_i,
  output logic                                 s_ready_o,
  input  wire logic [ips_pkg::IN_TDATA_W-1:0]  s_data_i,
  input  wire logic                            s_user_i,
  input  wire logic                            s_last_i,
  output logic                                 push_valid_o,
  input  wire logic                            push_ready_i,
  output ips_pkg::cmd_t                        push_cmd_o
);
  import ips_pkg::*;

  localparam int SMP_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((1 << SMP_W) - 1);

  assign s_ready_o    = push_ready_i;
  assign push_valid_o = s_valid_i;

  always_comb begin
    push_cmd_o.sample = s_data_i[SAMPLE_W-1:0] & SMP_MASK;
    if (s_user_i) begin
      push_cmd_o.op = OP_READ;
    end else if (s_last_i) begin
      push_cmd_o.op = OP_LOAD_LAST;
    end else begin
      push_cmd_o.op = OP_LOAD;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ips_queue.sv
`default_nettype none

module ips_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire ips_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output ips_pkg::cmd_t      pop_cmd_o
);
  import ips_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              push, pop;

  assign push_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ips_div.sv
`default_nettype none

module ips_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    shifted, diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle
  assign shifted    = {rem_q, quo_q[DVD_W-1]};
  assign ge         = (shifted >= {1'b0, dvs_q});
  assign diff       = shifted - {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/ips_back.sv
`default_nettype none

module ips_back #(
  parameter int MAX_SAMPLES = 2048,
  parameter int ADC_BITS    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ips_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  input  wire ips_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output ips_pkg::res_t      res_o,
  input  wire logic          res_ready_i
);
  import ips_pkg::*;

  localparam int SMP_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int PROD_W = SMP_W + CNT_W;
  localparam int LIM_W  = SUM_W + 1;
  localparam int THRN_W = THR_W + CNT_W;
  localparam int MIN_W  = (CNT_W > MINC_W) ? CNT_W : MINC_W;

  state_e state_q, state_d;

  // Sample store
  logic [SMP_W-1:0]  mem_q [MAX_SAMPLES];
  logic [SMP_W-1:0]  mem_rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  logic [CNT_W-1:0]  cnt_q, idx_q, iss_q, n_q, acc_n_q;
  logic [PED_W-1:0]  ped_q;
  logic              last_q;
  logic [PASS_W-1:0] pass_q;
  logic [SUM_W-1:0]  acc_sum_q, sum_q;
  logic [THRN_W-1:0] thrn_q;
  logic [LIM_W-1:0]  lim_q;
  logic              v1_q, v2_q;
  logic [PROD_W-1:0] prod_q;
  logic [SMP_W-1:0]  s2_q;
  logic              res_vld_q;
  res_t              res_q;

  logic              slot_free, rd_ok, store_room, iss_act, scan_done, take;
  logic              pass_fail, pass_last, use_div;
  logic [PASS_W-1:0] npass;
  logic [CNT_W-1:0]  new_n, rd_pos;
  logic [SUM_W-1:0]  new_sum;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  // Control decode
  logic pop, do_load, do_read, do_est, do_init, do_lim, do_pass_end, div_start;
  logic res_load_rd, res_load_rep, final_rd;

  assign slot_free  = !res_vld_q || res_ready_i;
  assign rd_ok      = (idx_q < cnt_q);
  assign store_room = (cnt_q < CNT_W'(MAX_SAMPLES));
  assign rd_pos     = cnt_q - idx_q - CNT_W'(1);
  assign final_rd   = ((idx_q + CNT_W'(1)) == cnt_q);
  assign npass      = (cfg_i.passes == '0) ? PASS_W'(1) : cfg_i.passes;
  assign iss_act    = (state_q == ST_SCAN) && (iss_q < cnt_q);
  assign scan_done  = !iss_act && !v1_q && !v2_q;
  assign take       = (pass_q == '0) || (LIM_W'(prod_q) < lim_q);
  // An empty pass stops iteration even when the minimum is zero
  assign pass_fail  = (n_q == '0) || (MIN_W'(n_q) < MIN_W'(cfg_i.min_count));
  assign new_n      = pass_fail ? acc_n_q : n_q;
  assign new_sum    = pass_fail ? acc_sum_q : sum_q;
  assign pass_last  = pass_fail ||
                      (({1'b0, pass_q} + (PASS_W+1)'(1)) == {1'b0, npass});
  assign use_div    = cfg_i.enable && (new_n != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (cmd_i.op == OP_LOAD_LAST) begin
            state_d = ST_INIT;
          end else if (cmd_i.op == OP_READ && rd_ok) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ:     state_d = ST_IDLE;
      ST_INIT:     state_d = ST_LIM;
      ST_LIM:      state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        if (!pass_last) begin
          state_d = ST_INIT;
        end else if (use_div) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop          = 1'b0;
    do_load      = 1'b0;
    do_read      = 1'b0;
    do_est       = 1'b0;
    do_init      = 1'b0;
    do_lim       = 1'b0;
    do_pass_end  = 1'b0;
    div_start    = 1'b0;
    res_load_rd  = 1'b0;
    res_load_rep = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = iss_q[ADDR_W-1:0];
    case (state_q)
      ST_IDLE: begin
        // a readout that yields a result waits for a free output slot
        pop = cmd_valid_i && (cmd_i.op != OP_READ || !rd_ok || slot_free);
        if (pop) begin
          case (cmd_i.op)
            OP_LOAD:      do_load = 1'b1;
            OP_LOAD_LAST: begin
              do_load = 1'b1;
              do_est  = 1'b1;
            end
            OP_READ:      do_read = rd_ok;
            default:      do_load = 1'b0;
          endcase
        end
        mem_re    = do_read;
        mem_raddr = rd_pos[ADDR_W-1:0];
      end
      ST_READ:     res_load_rd = 1'b1;
      ST_INIT:     do_init = 1'b1;
      ST_LIM:      do_lim = 1'b1;
      ST_SCAN:     mem_re = iss_act;
      ST_PASS_END: begin
        do_pass_end = 1'b1;
        div_start   = pass_last && use_div;
      end
      ST_DIV:      res_load_rep = 1'b0;
      ST_REPORT:   res_load_rep = slot_free;
      default:     pop = 1'b0;
    endcase
  end

  assign cmd_ready_o = pop;
  assign mem_we      = do_load && store_room;
  assign mem_waddr   = cnt_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cmd_i.sample[SMP_W-1:0];
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_raddr];
    end
  end

  ips_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_ips_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (new_sum),
    .divisor_i  (new_n),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      ped_q     <= '0;
      pass_q    <= '0;
      acc_sum_q <= '0;
      acc_n_q   <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= iss_act;
      v2_q    <= v1_q;
      if (mem_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (do_read) begin
        if (final_rd) begin
          cnt_q <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      if (do_est) begin
        pass_q    <= '0;
        acc_sum_q <= '0;
        acc_n_q   <= '0;
      end
      if (do_pass_end) begin
        if (!pass_fail) begin
          acc_sum_q <= sum_q;
          acc_n_q   <= n_q;
          pass_q    <= pass_q + PASS_W'(1);
        end
        if (pass_last && !use_div) begin
          ped_q <= '0;
        end
      end
      if (state_q == ST_DIV && div_done) begin
        ped_q <= div_quo[PED_W-1:0];
      end
      if (res_load_rep) begin
        idx_q <= '0;
      end
      if (res_load_rd || res_load_rep) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Scan datapath: read, multiply, compare and accumulate
  always_ff @(posedge clk_i) begin
    if (do_read) begin
      last_q <= final_rd;
    end
    if (do_init) begin
      thrn_q <= THRN_W'(cfg_i.threshold) * THRN_W'(acc_n_q);
    end
    if (do_lim) begin
      lim_q <= LIM_W'(acc_sum_q) + LIM_W'(thrn_q);
      iss_q <= '0;
      sum_q <= '0;
      n_q   <= '0;
    end else begin
      if (iss_act) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      if (v2_q && take) begin
        sum_q <= sum_q + SUM_W'(s2_q);
        n_q   <= n_q + CNT_W'(1);
      end
    end
    prod_q <= PROD_W'(mem_rd_q) * PROD_W'(acc_n_q);
    s2_q   <= mem_rd_q;
    if (res_load_rd) begin
      res_q.kind      <= KIND_SAMPLE;
      res_q.pedestal  <= ped_q;
      res_q.corrected <= CORR_W'(mem_rd_q) - CORR_W'(ped_q);
      res_q.last      <= last_q;
    end else if (res_load_rep) begin
      res_q.kind      <= KIND_REPORT;
      res_q.pedestal  <= ped_q;
      res_q.corrected <= '0;
      res_q.last      <= 1'b0;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/iterative_pedestal_subtract.sv
`default_nettype none

// Pedestal estimation and subtraction for one ADC channel. Load items
// (tuser 0) write one sample each into the sample store while it has room;
// the item with tlast set also starts the estimate and produces one report
// item (tuser 0) that carries the floored pedestal. Readout items (tuser 1)
// return the stored samples newest first, each minus the pedestal, with
// tlast on the oldest. A front stage classifies items into a four-entry
// command queue, so input keeps flowing while the back end is busy or its
// output register waits, until the queue is full. A readout reads the
// store in the idle state and forms its result in the read state, as the
// store read is registered. The estimate makes up to P passes over the N
// stored samples, each streaming the store through one multiply-compare-
// accumulate pipe, then a bit-serial divide forms the mean (SUM_W = sample
// bits plus count bits, 24 at the default size) before the report.
// Configuration writes are taken every cycle.

module iterative_pedestal_subtract #(
  parameter int MAX_SAMPLES = 2048,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ips_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [11:0] sample
  input  wire logic                              s_axis_tuser,  // mode
  input  wire logic                              s_axis_tlast,  // last_sample
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ips_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [11:0] pedestal,
                                                                // [24:12] corrected
  output logic                                   m_axis_tuser,  // kind
  output logic                                   m_axis_tlast,  // last_out
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ips_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ips_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - PED_W - CORR_W;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= RST_ENABLE;
      cfg_q.passes    <= RST_PASSES;
      cfg_q.threshold <= RST_THRESHOLD;
      cfg_q.min_count <= RST_MIN_COUNT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE:    cfg_q.enable    <= cfg_data_i[0];
        CFG_PASSES:    cfg_q.passes    <= cfg_data_i[PASS_W-1:0];
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[THR_W-1:0];
        CFG_MIN_COUNT: cfg_q.min_count <= cfg_data_i[MINC_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  ips_front #(
    .ADC_BITS (ADC_BITS)
  ) u_ips_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .s_last_i     (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ips_queue u_ips_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ips_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ADC_BITS    (ADC_BITS)
  ) u_ips_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .cfg_i       (cfg_q),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res.corrected, res.pedestal};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> rtl/ips_checker.sv
`default_nettype none

module ips_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [ips_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import ips_pkg::*;

  // A stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // A pedestal report carries no sample and no end mark
  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPORT) |->
      (m_axis_tdata[24:12] == '0) && !m_axis_tlast && (m_axis_tdata[31:25] == '0))
    else $error("pedestal report carries sample fields");

  // With a zero pedestal the corrected value is the raw sample, never negative
  a_zero_ped_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE) && (m_axis_tdata[11:0] == '0) |->
      !m_axis_tdata[24])
    else $error("negative corrected value with zero pedestal");

endmodule

bind iterative_pedestal_subtract ips_checker u_ips_checker (.*);

`default_nettype wire
